@@ hw/rtl/erm_pkg.sv @@
`timescale 1ns / 1ps

package erm_pkg;

    // Ring of instant rates
    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int RATE_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int INTERVAL_W = 32;
    localparam int SUM_W      = RATE_W + $clog2(RING_DEPTH);

    // count * 1e6 is built one hex digit of the constant per cycle, MSB first
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = 5;
    localparam logic [MUL_DIGITS*DIGIT_W-1:0] US_PER_S = 20'd1000000;
    localparam int MUL_W      = COUNT_W + MUL_DIGITS * DIGIT_W;

    // Q24.8: eight fraction bits appended before the division
    localparam int FRAC_W     = 8;
    localparam int DIV_NUM_W  = MUL_W + FRAC_W;
    localparam int DIV_Q_W    = 32;
    localparam int DIV_HI_W   = DIV_NUM_W - DIV_Q_W;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    localparam int HEALTH_W = 2;
    localparam logic [HEALTH_W-1:0] HEALTH_RED    = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_YELLOW = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_GREEN  = 2'd2;

    typedef struct packed {
        logic                  operation;
        logic [INTERVAL_W-1:0] interval_us;
    } t_in_item;

    typedef struct packed {
        logic [RATE_W-1:0]   average_rate;
        logic [HEALTH_W-1:0] health;
    } t_out_item;

    typedef struct packed {
        logic             done;
        logic [MUL_W-1:0] product;
    } t_mul_res;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_Q_W-1:0]   denom;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_res;

endpackage

@@ hw/rtl/event_rate_monitor.sv @@
`timescale 1ns / 1ps

// Event rate meter. An event request (operation 0) bumps a saturating counter
// and is taken without leaving idle, giving no result. A poll request
// (operation 1) turns the count into an instant rate count*1e6/interval_us in
// Q24.8 Hz (saturating), stores it in a 16-entry ring, clears the count and
// returns the ring average with a red/yellow/green grade against the target
// rate. A poll runs a digit-serial multiply by 1e6 over five hex digits, a
// pass of the shared bit-serial divider for the rate, the ring update, the
// average launch, a second divider pass for the ring average, grading and
// loading the output register. A poll with zero interval goes straight to the
// done state, offers 0/red and leaves the count and ring unchanged. The input
// is held for the whole of a poll. The next request is taken from the cycle in
// which the result is offered, since the result sits in an output register. If
// that register still holds an earlier result under stall, the poll waits
// until it drains. The target rate may be written only while no poll is in
// progress.
module event_rate_monitor
    import erm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_in_item     i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_out_item    o_out_data
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL      = 8'b0000_0010,
        S_DIV_RATE = 8'b0000_0100,
        S_RING     = 8'b0000_1000,
        S_AVG_GO   = 8'b0001_0000,
        S_DIV_AVG  = 8'b0010_0000,
        S_GRADE    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    localparam int A10_W = RATE_W + 4;

    t_state               r_state;
    logic [RATE_W-1:0]    r_desired;
    logic [COUNT_W-1:0]   r_count;
    logic [RING_AW-1:0]   r_idx;
    logic [SUM_W-1:0]     r_sum;
    logic [RING_DEPTH-1:0] r_valid;
    logic [INTERVAL_W-1:0] r_interval;
    logic [RATE_W-1:0]    r_rate;
    logic [RATE_W-1:0]    r_avg;
    logic [HEALTH_W-1:0]  r_health;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 in_acc;
    logic                 is_poll;
    logic                 zero_iv;
    logic                 slot_free;
    logic [RATE_W-1:0]    old_rate;
    logic [SUM_W-1:0]     n_sum;
    logic [A10_W-1:0]     a10;
    logic [A10_W-1:0]     t9;
    logic [RATE_W:0]      a2;
    logic [HEALTH_W-1:0]  n_health;

    logic                 mul_start;
    t_mul_res             mul_res;
    t_div_req             div_req;
    t_div_res             div_res;
    logic [RATE_W-1:0]    ram_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_poll     = (i_in_data.operation == OP_POLL);
    assign zero_iv     = (i_in_data.interval_us == '0);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign mul_start   = in_acc && is_poll && !zero_iv;

    always_comb begin
        old_rate = r_valid[r_idx] ? ram_rdata : '0;
        n_sum    = r_sum - SUM_W'(old_rate) + SUM_W'(r_rate);

        a10 = (A10_W'(r_avg) << 3) + (A10_W'(r_avg) << 1);
        t9  = (A10_W'(r_desired) << 3) + A10_W'(r_desired);
        a2  = {r_avg, 1'b0};
        priority if (a10 > t9) begin
            n_health = HEALTH_GREEN;
        end else if (a2 > {1'b0, r_desired}) begin
            n_health = HEALTH_YELLOW;
        end else begin
            n_health = HEALTH_RED;
        end

        div_req = '{start: 1'b0, numer: '0, denom: '0};
        if (r_state == S_MUL && mul_res.done) begin
            div_req = '{start: 1'b1,
                        numer: {mul_res.product, FRAC_W'(0)},
                        denom: r_interval};
        end else if (r_state == S_AVG_GO) begin
            div_req = '{start: 1'b1,
                        numer: DIV_NUM_W'(r_sum),
                        denom: DIV_Q_W'(RING_DEPTH)};
        end
    end

    erm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_count (r_count),
        .o_res   (mul_res)
    );

    erm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    erm_ram #(
        .WIDTH (RATE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RING),
        .i_waddr (r_idx),
        .i_wdata (r_rate),
        .i_re    (mul_start),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_desired   <= 32'd2560;
            r_count     <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desired <= i_cfg_wdata;
            end
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!is_poll) begin
                            if (r_count != '1) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (zero_iv) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_res.done) begin
                        r_state <= S_DIV_RATE;
                    end
                end
                S_DIV_RATE: begin
                    if (div_res.done) begin
                        r_state <= S_RING;
                    end
                end
                S_RING: begin
                    r_sum          <= n_sum;
                    r_valid[r_idx] <= 1'b1;
                    r_count        <= '0;
                    r_idx <= (r_idx == RING_AW'(RING_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    r_state        <= S_AVG_GO;
                end
                S_AVG_GO: begin
                    r_state <= S_DIV_AVG;
                end
                S_DIV_AVG: begin
                    if (div_res.done) begin
                        r_state <= S_GRADE;
                    end
                end
                S_GRADE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath holding registers
    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_interval <= i_in_data.interval_us;
        end
        if (in_acc && is_poll && zero_iv) begin
            r_avg    <= '0;
            r_health <= HEALTH_RED;
        end
        if (r_state == S_DIV_RATE && div_res.done) begin
            r_rate <= div_res.quot;
        end
        if (r_state == S_DIV_AVG && div_res.done) begin
            r_avg <= div_res.quot;
        end
        if (r_state == S_GRADE) begin
            r_health <= n_health;
        end
        if (r_state == S_DONE && slot_free) begin
            r_out_data <= '{average_rate: r_avg, health: r_health};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_zero_poll_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_poll && zero_iv) |=>
            ($stable(r_count) && $stable(r_sum) && $stable(r_idx)))
        else $error("zero-interval poll changed state");

    a_ring_store_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RING) |=> (r_count == '0) && r_valid[$past(r_idx)])
        else $error("ring store did not clear count or mark slot");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    a_green_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.health == HEALTH_GREEN) |->
            (r_out_data.average_rate != '0))
        else $error("green grade with zero average");

endmodule

@@ hw/rtl/erm_ram.sv @@
`timescale 1ns / 1ps

module erm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/erm_mul.sv @@
`timescale 1ns / 1ps

module erm_mul
    import erm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COUNT_W-1:0] i_count,
    output t_mul_res           o_res
);

    localparam int DIG_CW = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;
    localparam int PART_W = COUNT_W + DIGIT_W;

    logic               r_busy;
    logic               r_done;
    logic [DIG_CW-1:0]  r_dig;
    logic [COUNT_W-1:0] r_cnt;
    logic [MUL_W-1:0]   r_acc;

    logic [DIGIT_W-1:0] digit;
    logic [PART_W-1:0]  part;
    logic [MUL_W-1:0]   n_acc;

    always_comb begin
        digit = US_PER_S[DIGIT_W * (MUL_DIGITS - 1 - int'(r_dig)) +: DIGIT_W];
        part  = PART_W'(r_cnt) * PART_W'(digit);
        n_acc = (r_acc << DIGIT_W) + MUL_W'(part);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_dig == DIG_CW'(MUL_DIGITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= i_count;
            r_acc <= '0;
            r_dig <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_dig <= r_dig + 1'b1;
        end
    end

    assign o_res = '{done: r_done, product: r_acc};

endmodule

@@ hw/rtl/erm_div.sv @@
`timescale 1ns / 1ps

module erm_div
    import erm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    localparam int STEP_W = $clog2(DIV_Q_W);

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [STEP_W-1:0]  r_step;
    logic [DIV_Q_W-1:0] r_rem;
    logic [DIV_Q_W-1:0] r_den;
    logic [DIV_Q_W-1:0] r_sh;

    logic [DIV_Q_W-1:0] hi;
    logic [DIV_Q_W:0]   rem_sh;
    logic [DIV_Q_W:0]   diff;
    logic               ge;

    always_comb begin
        hi     = DIV_Q_W'(i_req.numer[DIV_NUM_W-1 -: DIV_HI_W]);
        rem_sh = {r_rem, r_sh[DIV_Q_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DIV_Q_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle; quotient bits shift
    // in behind the low numerator bits as those are consumed.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= hi;
            r_sh   <= i_req.numer[DIV_Q_W-1:0];
            r_den  <= i_req.denom;
            r_sat  <= hi >= i_req.denom;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_Q_W-1:0] : rem_sh[DIV_Q_W-1:0];
            r_sh   <= {r_sh[DIV_Q_W-2:0], ge};
            r_step <= r_step + 1'b1;
        end
    end

    assign o_res = '{done: r_done, quot: r_sat ? '1 : r_sh};

endmodule

@@ tb/sv/tb_event_rate_monitor.sv @@
`timescale 1ns / 1ps

import erm_pkg::*;

class rate_tracker;
    localparam logic [63:0] ONE_SECOND_Q8 = 64'd256000000;
    localparam int unsigned MAX_REPORTS = 10;

    logic [RATE_W-1:0]  target_rate;
    logic [COUNT_W-1:0] event_count;
    logic [RATE_W-1:0]  ring [RING_DEPTH];
    int unsigned        slot;
    logic [63:0]        ring_total;
    t_out_item          expected_readings [$];
    int unsigned        bad_readings;

    function new();
        target_rate  = 32'd2560;
        event_count  = '0;
        slot         = 0;
        ring_total   = '0;
        bad_readings = 0;
        foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_target(logic [RATE_W-1:0] value);
        target_rate = value;
    endfunction

    function int unsigned pending();
        return expected_readings.size();
    endfunction

    function void take_request(t_in_item req);
        logic [63:0]   quotient;
        logic [31:0]   rate;
        t_out_item     reading;
        if (req.operation == OP_EVENT) begin
            if (event_count != '1)
                event_count++;
            return;
        end
        reading.average_rate = '0;
        reading.health = HEALTH_RED;
        // a poll over no elapsed time leaves everything as it was
        if (req.interval_us == '0) begin
            expected_readings.push_back(reading);
            return;
        end
        quotient = ({32'd0, event_count} * ONE_SECOND_Q8) / {32'd0, req.interval_us};
        rate = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[31:0];
        event_count = '0;
        ring_total = ring_total - {32'd0, ring[slot]} + {32'd0, rate};
        ring[slot] = rate;
        slot = (slot + 1) % RING_DEPTH;
        reading.average_rate = 32'(ring_total / 64'(RING_DEPTH));
        if ({32'd0, reading.average_rate} * 64'd10 > {32'd0, target_rate} * 64'd9)
            reading.health = HEALTH_GREEN;
        else if ({32'd0, reading.average_rate} * 64'd2 > {32'd0, target_rate})
            reading.health = HEALTH_YELLOW;
        expected_readings.push_back(reading);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
        bad_readings++;
        if (bad_readings <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_reading(t_out_item got);
        t_out_item want;
        if (expected_readings.size() == 0) begin
            bad_readings++;
            if (bad_readings <= MAX_REPORTS)
                $display("unexpected result: rate %0h health %0d",
                         got.average_rate, got.health);
            return;
        end
        want = expected_readings.pop_front();
        if (got.average_rate !== want.average_rate)
            flag("average_rate", want.average_rate, got.average_rate);
        if (got.health !== want.health)
            flag("health", 32'(want.health), 32'(got.health));
    endfunction
endclass

module tb_event_rate_monitor;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned LONG_HOLD     = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;

    rate_tracker tracker;
    int unsigned items_sent   = 0;
    int unsigned hold_request = 0;
    bit          no_idle      = 1'b0;

    event_rate_monitor DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [31:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 25)
            return 32'($urandom_range(1, 64));
        if (r < 45)
            return 32'($urandom_range(2000, 100000));
        if (r < 90)
            return 32'($urandom_range(100000, 2000000));
        return $urandom;
    endfunction

    function automatic int unsigned pick_burst();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        if (r < 90)
            return $urandom_range(9, 20);
        return $urandom_range(21, 40);
    endfunction

    // entered and left at a falling edge
    task automatic send_request(t_in_item req);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do @(posedge clk); while (in_stall);
        tracker.take_request(req);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_event(logic [31:0] interval);
        t_in_item req;
        req.operation   = OP_EVENT;
        req.interval_us = interval;
        send_request(req);
    endtask

    task automatic send_poll(logic [31:0] interval);
        t_in_item req;
        req.operation   = OP_POLL;
        req.interval_us = interval;
        send_request(req);
    endtask

    // a burst of events closed by a poll; hot bursts push the rate to saturation
    task automatic send_sequence(bit hot);
        int unsigned burst;
        burst = hot ? $urandom_range(17, 24) : pick_burst();
        for (int unsigned n = 0; n < burst; n++) begin
            if (!hot && $urandom_range(0, 99) < 3)
                send_poll('0);
            send_event($urandom);
        end
        if (hot && $urandom_range(0, 99) < 90)
            send_poll(32'd1);
        else
            send_poll(pick_interval());
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_target(logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        tracker.set_target(value);
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && $urandom_range(0, 99) < 20) begin
                stall_left = idle_gap();
            end
            if (stall_left != 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reading(out_data);
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] target;
        int unsigned quota;
        int unsigned start;
        tracker   = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no events yet, then a poll over no elapsed time
        send_poll(32'd1000);
        send_poll('0);
        repeat (3) send_event($urandom);
        // the count must survive the empty poll
        send_poll('0);
        send_poll('1);
        for (int unsigned i = 0; i < 17; i++)
            send_event((i == 0) ? '1 : (i == 1) ? '0 : $urandom);
        send_poll(32'd1);

        for (int unsigned phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: target = '0;
                1: target = '1;
                2: target = 32'($urandom_range(1, 40)) << 8;
                3: target = $urandom;
                4: target = 32'($urandom_range(1, 400)) << 8;
                default: target = 32'($urandom_range(1, 40)) << 8;
            endcase
            write_target(target);
            no_idle = (phase == 5);
            if (phase == 4)
                hold_request = LONG_HOLD;
            quota = (phase == 1) ? 420 : 280;
            start = items_sent;
            while (items_sent - start < quota) begin
                if ($urandom_range(0, 99) < 8)
                    send_poll(pick_interval());
                else
                    send_sequence(phase == 1);
            end
        end

        wait_idle();
        if (tracker.bad_readings == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
